@@ sv/cps_pkg.sv @@
// Shared types, constants, bit-reorder, sum and rotate functions of the scrambler.
`timescale 1ns / 1ps

package cps_pkg;

	localparam logic [63:0] SCR_MASK   = 64'h8E55_AA1B_3999_E8AA;
	localparam logic [31:0] GEN_INIT_A = 32'hF1EA_5EED;
	localparam logic [7:0]  REPLY_HDR  = 8'hAA;
	localparam logic [3:0]  LEN_BLANK  = 4'h1;
	localparam logic [3:0]  LEN_VALUE  = 4'h9;

	localparam int unsigned IN_DATA_W  = 72;
	localparam int unsigned OUT_DATA_W = 88;

	typedef enum logic {
		ACT_SEED = 1'b0,
		ACT_NEXT = 1'b1
	} action_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic round_en;
		logic form_en;
	} cps_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic    out_free;
	} cps_stat_t;

	// For each set mask bit 63-i, mask scanned from the top, challenge bit i is
	// shifted into the seed from the low end.
	function automatic logic [31:0] gather_seed(input logic [63:0] ch);
		logic [31:0] s;
		s = '0;
		for (int i = 0; i < 64; i++) begin
			if (SCR_MASK[63 - i]) begin
				s = {s[30:0], ch[i]};
			end
		end
		return s;
	endfunction

	// Result bits go, from bit 0 up, to payload bit 63-i at each set mask bit i.
	function automatic logic [63:0] spread_value(input logic [31:0] v);
		logic [63:0] r;
		int unsigned j;
		r = '0;
		j = 0;
		for (int i = 0; i < 64; i++) begin
			if (SCR_MASK[i]) begin
				r[63 - i] = v[j[4:0]];
				j = j + 1;
			end
		end
		return r;
	endfunction

	function automatic logic [7:0] reply_sum(input logic [3:0] len, input logic [7:0] seq,
			input logic [63:0] pay);
		logic [7:0] s;
		s = REPLY_HDR + {4'h0, len} + seq;
		for (int k = 0; k < 8; k++) begin
			s = s + pay[8*k +: 8];
		end
		return s;
	endfunction

	function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned k);
		return (x << k) | (x >> (32 - k));
	endfunction

endpackage

@@ sv/cps_dp.sv @@
// Datapath: generator state, one round unit, reply assembly and output register.
`timescale 1ns / 1ps

module cps_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  cps_pkg::cps_cmd_t               cmd,
	output cps_pkg::cps_stat_t              stat,
	input  logic                            in_action,
	input  logic [63:0]                     in_challenge,
	input  logic [7:0]                      in_seq,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [cps_pkg::OUT_DATA_W-1:0]  out_data
);
	import cps_pkg::*;

	logic [31:0] gen_a_q, gen_b_q, gen_c_q, gen_d_q;
	logic [31:0] rnd_q;
	action_t     action_q;
	logic [7:0]  seq_q;
	logic        out_valid_q;
	logic [3:0]  len_q;
	logic [7:0]  seq_out_q;
	logic [63:0] pay_q;
	logic [7:0]  sum_q;

	logic [31:0] e_w, na_w, nb_w, nc_w, nd_w;
	logic [31:0] seed_w;
	logic [63:0] pay_w;
	logic [3:0]  len_w;

	assign seed_w = gather_seed(in_challenge);

	assign e_w  = gen_a_q - rotl32(gen_b_q, 27);
	assign na_w = gen_b_q ^ rotl32(gen_c_q, 17);
	assign nb_w = gen_c_q + gen_d_q;
	assign nc_w = gen_d_q + e_w;
	assign nd_w = na_w + e_w;

	assign len_w = (action_q == ACT_NEXT) ? LEN_VALUE : LEN_BLANK;
	assign pay_w = (action_q == ACT_NEXT) ? spread_value(rnd_q) : 64'h0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_a_q     <= '0;
			gen_b_q     <= '0;
			gen_c_q     <= '0;
			gen_d_q     <= '0;
			out_valid_q <= 1'b0;
			action_q    <= ACT_SEED;
		end else begin
			if (cmd.load) begin
				action_q <= action_t'(in_action);
				if (action_t'(in_action) == ACT_SEED) begin
					gen_a_q <= GEN_INIT_A;
					gen_b_q <= seed_w;
					gen_c_q <= seed_w;
					gen_d_q <= seed_w;
				end
			end else if (cmd.round_en) begin
				gen_a_q <= na_w;
				gen_b_q <= nb_w;
				gen_c_q <= nc_w;
				gen_d_q <= nd_w;
			end
			if (cmd.form_en) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			seq_q <= in_seq;
		end
		if (cmd.round_en) begin
			rnd_q <= nd_w;
		end
		if (cmd.form_en) begin
			len_q     <= len_w;
			seq_out_q <= seq_q;
			pay_q     <= pay_w;
			sum_q     <= reply_sum(len_w, seq_q, pay_w);
		end
	end

	assign stat.out_free = !out_valid_q || out_ready;
	assign out_valid     = out_valid_q;
	assign out_data      = {4'h0, sum_q, pay_q, seq_out_q, len_q};

endmodule

@@ sv/cps_ctrl.sv @@
// Controller: sequences request capture, generator rounds and reply hand-off.
`timescale 1ns / 1ps

module cps_ctrl #(
	parameter int unsigned SEED_ROUNDS = 23
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                in_action,
	input  cps_pkg::cps_stat_t  stat,
	output cps_pkg::cps_cmd_t   cmd
);
	import cps_pkg::*;

	localparam int unsigned CW = $clog2(SEED_ROUNDS + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEED,
		ST_NEXT,
		ST_FINISH
	} state_t;

	state_t        state_q;
	logic [CW-1:0] cnt_q;
	logic          accept_w;

	assign in_ready = (state_q == ST_IDLE);
	assign accept_w = in_valid && in_ready;

	always_comb begin
		cmd.load     = accept_w;
		cmd.round_en = (state_q == ST_SEED) || (state_q == ST_NEXT);
		cmd.form_en  = (state_q == ST_FINISH) && stat.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (accept_w) begin
						state_q <= (action_t'(in_action) == ACT_SEED) ? ST_SEED : ST_NEXT;
					end
				end
				ST_SEED: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(SEED_ROUNDS - 1)) begin
						state_q <= ST_FINISH;
					end
				end
				ST_NEXT: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (stat.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ sv/challenge_prng_scrambler.sv @@
// Top level of the challenge-response scrambler with its 32-bit generator.
//
// Usage: one request is a transaction on the s_axis group. s_axis_tuser carries
// the request kind (0 seed from challenge, 1 next scrambled value), s_axis_tdata
// the challenge and sequence number. Each request yields exactly one reply
// transaction on m_axis with length, echoed sequence, payload and checksum.
// After acceptance, a seed request runs SEED_ROUNDS generator rounds and a next
// request one round before the reply is formed in the output register. The
// generator round unit does one round per cycle; a new request can be taken in
// the cycle after the reply is registered.
// The reply sits in an output register, so a request can be accepted while the
// previous reply waits; if the receiver stalls with a reply still pending, the
// new reply is held inside until the register frees and s_axis_tready stays low.
// Reset clears the generator state to zero and empties the output register; a
// next request before any seed runs on the all-zero state.
`timescale 1ns / 1ps

module challenge_prng_scrambler #(
	parameter int unsigned SEED_ROUNDS = 23
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// [63:0] challenge, [71:64] sequence_req
	input  logic [cps_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// [0] action
	input  logic                            s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// [3:0] reply_length, [11:4] sequence_echo, [75:12] payload, [83:76] checksum,
	// [87:84] zero
	output logic [cps_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
	import cps_pkg::*;

	cps_cmd_t  cmd;
	cps_stat_t stat;

	cps_ctrl #(
		.SEED_ROUNDS(SEED_ROUNDS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_action(s_axis_tuser),
		.stat     (stat),
		.cmd      (cmd)
	);

	cps_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.in_action   (s_axis_tuser),
		.in_challenge(s_axis_tdata[63:0]),
		.in_seq      (s_axis_tdata[71:64]),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_data    (m_axis_tdata)
	);

endmodule
